[rtl/cmsu_pkg.sv]
// Shared types, sizes and codes of the CAN signal map unpacker.
// No dependencies; used by the core, the multiplier and the checker.
`default_nettype none
package cmsu_pkg;

    localparam int ITEM_SLOTS          = 64;
    localparam int MESSAGE_SLOTS       = 16;
    localparam int GAIN_FRACTION_BITS  = 16;
    localparam int VALUE_FRACTION_BITS = 5;

    // index and count widths
    localparam int IXW = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;
    localparam int ICW = $clog2(ITEM_SLOTS + 1);
    localparam int MXW = (MESSAGE_SLOTS > 1) ? $clog2(MESSAGE_SLOTS) : 1;
    localparam int MCW = $clog2(MESSAGE_SLOTS + 1);

    // rescale from gain fraction to value fraction
    localparam int FRAC_DIFF = GAIN_FRACTION_BITS - VALUE_FRACTION_BITS;
    localparam int SHR       = (FRAC_DIFF >= 0) ? FRAC_DIFF : 0;
    localparam int SHL       = (FRAC_DIFF < 0) ? -FRAC_DIFF : 0;

    localparam logic [31:0] MAX_ID     = 32'h1fff_ffff;
    localparam logic [7:0]  MAX_OFFSET = 8'd63;
    localparam logic [7:0]  MAX_LENGTH = 8'd32;

    // shift-add multiplier sizes
    localparam int MUL_A = 33;
    localparam int MUL_B = 32;
    localparam int MUL_P = MUL_A + MUL_B;
    localparam int MUL_CW = $clog2(MUL_B + 1);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_WRITE    = 2'd1,
        KIND_UNMAPPED = 2'd2
    } t_kind;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ID     = 3'd1;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_MSG_FULL   = 3'd4;
    localparam logic [2:0] ST_ITEM_FULL  = 3'd5;

    typedef struct packed {
        logic [7:0]  vofs;
        logic [5:0]  len;
        logic [5:0]  off;
        logic [15:0] param;
        logic [31:0] gain;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [MUL_A-1:0]  a;
        logic [MUL_B-1:0]  b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [MUL_P-1:0]  p;
    } t_mul_rsp;

endpackage
`default_nettype wire

[rtl/can_signal_map_unpacker_core.sv]
// Top level of the CAN signal map unpacker: map tables, sequencer, scaling.
// Depends on cmsu_pkg and cmsu_mul.
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  request item, op in tuser
//  m_axis    out  m_axis_tvalid / m_axis_tready  result item, kind in tuser
//
// A request is taken only when the block is idle. An add scans the message
// table (one entry a cycle); a rejected add gives its status item without the
// scan. A frame scans the table, then for each mapped signal reads the item,
// multiplies on the 32-step shift-add multiplier and saturates. A clear gives
// no item. Reset empties the map at once. A stalled result holds the sequencer.
`default_nettype none
module can_signal_map_unpacker_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: can_id[31:0] param_index[47:32] bit_offset[55:48]
    //        bit_length[63:56] gain[95:64] value_offset[103:96]
    //        data_low[135:104] data_high[167:136]
    input  wire logic [167:0] s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: status[2:0] message_count[7:3] target_param[23:8] value[55:24]
    output logic [55:0]       m_axis_tdata,
    // tuser: kind[1:0]
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    import cmsu_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_ADD  = 8'b0000_0100,
        S_READ = 8'b0000_1000,
        S_LOAD = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_SAT  = 8'b0100_0000,
        S_HOLD = 8'b1000_0000
    } t_state;

    t_state r_state;

    // latched request
    logic [1:0]  r_op;
    logic [31:0] r_id;
    logic [15:0] r_param;
    logic [5:0]  r_off;
    logic [5:0]  r_len;
    logic [31:0] r_gain;
    logic [7:0]  r_vofs;
    logic [31:0] r_lo;
    logic [31:0] r_hi;

    // map tables
    logic [28:0]    r_ident [MESSAGE_SLOTS];
    logic [IXW-1:0] r_head  [MESSAGE_SLOTS];
    logic [IXW-1:0] r_tail  [MESSAGE_SLOTS];
    t_item          r_item_mem [ITEM_SLOTS];
    logic [IXW-1:0] r_link_mem [ITEM_SLOTS];
    t_item          r_rd_item;
    logic [IXW-1:0] r_rd_link;

    logic [MCW-1:0] r_msg_cnt;
    logic [ICW-1:0] r_item_cnt;

    // walk state
    logic [MCW-1:0] r_i;
    logic [MXW-1:0] r_m;
    logic           r_found;
    logic [IXW-1:0] r_idx;
    logic [IXW-1:0] r_next;
    logic           r_end;
    logic           r_neg;
    logic [15:0]    r_wparam;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [2:0]  r_out_status;
    logic [4:0]  r_out_count;
    logic [15:0] r_out_param;
    logic [31:0] r_out_value;
    logic        r_out_last;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    cmsu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    logic        in_fire;
    logic        out_fire;
    logic [31:0] src;
    logic [31:0] shifted;
    logic [32:0] mask33;
    logic [31:0] field;
    logic [33:0] sum;
    logic [32:0] mag_a;
    logic [31:0] mag_b;
    logic        p_zero;
    logic        sat_neg;
    logic [31:0] lim;
    logic [MUL_P-1:0] qs;
    logic [31:0] q;
    logic [31:0] sval;
    logic        id_hit;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = r_out_valid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    assign id_hit = ({3'b000, r_ident[r_i[MXW-1:0]]} == r_id);

    // extract the field and form operand magnitudes
    always_comb begin
        src     = r_rd_item.off[5] ? r_hi : r_lo;
        shifted = src >> r_rd_item.off[4:0];
        mask33  = (33'd1 << r_rd_item.len) - 33'd1;
        field   = shifted & mask33[31:0];
        sum     = {2'b00, field} + {{26{r_rd_item.vofs[7]}}, r_rd_item.vofs};
        mag_a   = sum[33] ? 33'(~sum + 34'd1) : sum[32:0];
        mag_b   = r_rd_item.gain[31] ? (~r_rd_item.gain + 32'd1) : r_rd_item.gain;
        mul_req.start = (r_state == S_LOAD);
        mul_req.a     = mag_a;
        mul_req.b     = mag_b;
    end

    // rescale, saturate and apply sign
    always_comb begin
        p_zero  = (mul_rsp.p == '0);
        sat_neg = r_neg && !p_zero;
        lim     = sat_neg ? 32'h8000_0000 : 32'h7fff_ffff;
        qs      = mul_rsp.p >> SHR;
        if (qs > (MUL_P'(lim) >> SHL)) begin
            q = lim;
        end else begin
            q = 32'(qs) << SHL;
        end
        sval = sat_neg ? (32'd0 - q) : q;
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_msg_cnt   <= '0;
            r_item_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                        if (s_axis_tuser == OP_ADD) begin
                            r_end <= 1'b1;
                            if (s_axis_tdata[31:0] > MAX_ID) begin
                                r_out_status <= ST_BAD_ID;
                                r_out_valid  <= 1'b1;
                                r_state      <= S_HOLD;
                            end else if (s_axis_tdata[55:48] > MAX_OFFSET) begin
                                r_out_status <= ST_BAD_OFFSET;
                                r_out_valid  <= 1'b1;
                                r_state      <= S_HOLD;
                            end else if (s_axis_tdata[63:56] > MAX_LENGTH) begin
                                r_out_status <= ST_BAD_LENGTH;
                                r_out_valid  <= 1'b1;
                                r_state      <= S_HOLD;
                            end else begin
                                r_state <= S_SCAN;
                            end
                            r_out_kind  <= KIND_STATUS;
                            r_out_count <= 5'(r_msg_cnt);
                            r_out_param <= '0;
                            r_out_value <= '0;
                            r_out_last  <= 1'b1;
                        end else if (s_axis_tuser == OP_FRAME) begin
                            r_state <= S_SCAN;
                        end else if (s_axis_tuser == OP_CLEAR) begin
                            r_msg_cnt  <= '0;
                            r_item_cnt <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_i == r_msg_cnt) begin
                        if (r_op == OP_ADD) begin
                            r_state <= S_ADD;
                        end else begin
                            r_out_kind   <= KIND_UNMAPPED;
                            r_out_status <= ST_OK;
                            r_out_count  <= '0;
                            r_out_param  <= '0;
                            r_out_value  <= '0;
                            r_out_last   <= 1'b1;
                            r_out_valid  <= 1'b1;
                            r_end        <= 1'b1;
                            r_state      <= S_HOLD;
                        end
                    end else if (id_hit) begin
                        r_m     <= r_i[MXW-1:0];
                        r_found <= 1'b1;
                        r_idx   <= r_head[r_i[MXW-1:0]];
                        r_state <= (r_op == OP_ADD) ? S_ADD : S_READ;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_ADD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_HOLD;
                    if (!r_found && r_msg_cnt == MCW'(MESSAGE_SLOTS)) begin
                        r_out_status <= ST_MSG_FULL;
                    end else if (r_item_cnt == ICW'(ITEM_SLOTS)) begin
                        r_out_status <= ST_ITEM_FULL;
                    end else begin
                        r_out_status <= ST_OK;
                        r_item_cnt   <= r_item_cnt + 1'b1;
                        if (!r_found) begin
                            r_msg_cnt   <= r_msg_cnt + 1'b1;
                            r_out_count <= 5'(r_msg_cnt + 1'b1);
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_neg    <= sum[33] ^ r_rd_item.gain[31];
                    r_wparam <= r_rd_item.param;
                    r_next   <= r_rd_link;
                    r_end    <= (r_idx == r_tail[r_m]);
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    if (mul_rsp.done) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_out_kind   <= KIND_WRITE;
                    r_out_status <= ST_OK;
                    r_out_count  <= '0;
                    r_out_param  <= r_wparam;
                    r_out_value  <= sval;
                    r_out_last   <= r_end;
                    r_out_valid  <= 1'b1;
                    r_state      <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_fire) begin
                        if (r_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_next;
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // latch request fields
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= s_axis_tuser;
            r_id    <= s_axis_tdata[31:0];
            r_param <= s_axis_tdata[47:32];
            r_off   <= s_axis_tdata[53:48];
            r_len   <= s_axis_tdata[61:56];
            r_gain  <= s_axis_tdata[95:64];
            r_vofs  <= s_axis_tdata[103:96];
            r_lo    <= s_axis_tdata[135:104];
            r_hi    <= s_axis_tdata[167:136];
        end
    end

    // update message tables on add
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD && !r_found && r_msg_cnt != MCW'(MESSAGE_SLOTS)) begin
            r_ident[r_msg_cnt[MXW-1:0]] <= r_id[28:0];
            if (r_item_cnt != ICW'(ITEM_SLOTS)) begin
                r_head[r_msg_cnt[MXW-1:0]] <= r_item_cnt[IXW-1:0];
                r_tail[r_msg_cnt[MXW-1:0]] <= r_item_cnt[IXW-1:0];
            end
        end else if (r_state == S_ADD && r_found && r_item_cnt != ICW'(ITEM_SLOTS)) begin
            r_tail[r_m] <= r_item_cnt[IXW-1:0];
        end
    end

    // item memory: write new descriptor, registered read at walk index
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD && r_item_cnt != ICW'(ITEM_SLOTS)
            && (r_found || r_msg_cnt != MCW'(MESSAGE_SLOTS))) begin
            r_item_mem[r_item_cnt[IXW-1:0]] <= '{vofs: r_vofs, len: r_len, off: r_off,
                                                 param: r_param, gain: r_gain};
        end
        r_rd_item <= r_item_mem[r_idx];
    end

    // link memory: chain the new item behind the old tail
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD && r_found && r_item_cnt != ICW'(ITEM_SLOTS)) begin
            r_link_mem[r_tail[r_m]] <= r_item_cnt[IXW-1:0];
        end
        r_rd_link <= r_link_mem[r_idx];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_value, r_out_param, r_out_count, r_out_status};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

[rtl/cmsu_mul.sv]
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on cmsu_pkg for widths and request/response types.
`default_nettype none
module cmsu_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cmsu_pkg::t_mul_req i_req,
    output cmsu_pkg::t_mul_rsp     o_rsp
);
    import cmsu_pkg::*;

    logic [MUL_A-1:0]  r_a;
    logic [MUL_A-1:0]  r_hi, n_hi;
    logic [MUL_B-1:0]  r_lo, n_lo;
    logic [MUL_CW-1:0] r_cnt;
    logic              r_run;
    logic              r_done;
    logic [MUL_A:0]    sum;

    // add the multiplicand when the low bit is set, then shift right
    always_comb begin
        sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
        n_hi = sum[MUL_A:1];
        n_lo = {sum[0], r_lo[MUL_B-1:1]};
    end

    // sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= MUL_CW'(MUL_B);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // hold operands and partial product
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_hi <= '0;
            r_lo <= i_req.b;
        end else if (r_run) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = {r_hi, r_lo};

endmodule
`default_nettype wire

[rtl/cmsu_checker.sv]
// Port-level checks of the CAN signal map unpacker, bound to the top level.
// Depends on cmsu_pkg for the kind and status codes.
`default_nettype none
module cmsu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    import cmsu_pkg::*;

    // no request is taken while a result waits
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request ready while a result is pending");

    // status and unmapped results close their request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_STATUS || m_axis_tuser == KIND_UNMAPPED))
        |-> m_axis_tlast)
        else $error("status or unmapped result without last");

    // error status only in add results
    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] != ST_OK) |-> (m_axis_tuser == KIND_STATUS))
        else $error("nonzero status outside an add result");

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind can_signal_map_unpacker_core cmsu_checker u_cmsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[verif/tb_can_signal_map_unpacker_core.sv]
// Self-checking testbench of can_signal_map_unpacker_core: random and directed
// map adds, frames and clears, with a map model that predicts every result item.
// Depends on cmsu_pkg and the RTL of the core.
`default_nettype none

import cmsu_pkg::*;

// Expected result item of the unpacker
typedef struct {
    t_kind       kind;
    logic [2:0]  status;
    logic [4:0]  msg_count;
    logic [15:0] param;
    logic [31:0] value;
    logic        last;
} t_unpack_result;

// Receive map model plus the queue of results it predicts
class unpack_scoreboard;
    localparam int CHAIN_END = ITEM_SLOTS;
    localparam int LINK_FREE = 255;

    logic [31:0]    msg_ident [MESSAGE_SLOTS];
    int             msg_head  [MESSAGE_SLOTS];
    logic [15:0]    it_param  [ITEM_SLOTS];
    logic [5:0]     it_off    [ITEM_SLOTS];
    logic [5:0]     it_len    [ITEM_SLOTS];
    logic [7:0]     it_vofs   [ITEM_SLOTS];
    logic [31:0]    it_gain   [ITEM_SLOTS];
    int             it_link   [ITEM_SLOTS];
    t_unpack_result pending_results[$];
    int             mismatches;

    function new();
        mismatches = 0;
        clear_map();
    endfunction

    function void clear_map();
        for (int i = 0; i < MESSAGE_SLOTS; i++) begin
            msg_head[i]  = CHAIN_END;
            msg_ident[i] = '0;
        end
        for (int i = 0; i < ITEM_SLOTS; i++) begin
            it_link[i] = LINK_FREE;
        end
    endfunction

    function int find_msg(logic [31:0] id);
        for (int i = 0; i < MESSAGE_SLOTS && msg_head[i] != CHAIN_END; i++) begin
            if (msg_ident[i] == id) return i;
        end
        return -1;
    endfunction

    function int count_msgs();
        int n;
        n = 0;
        while (n < MESSAGE_SLOTS && msg_head[n] != CHAIN_END) n++;
        return n;
    endfunction

    // (field + offset) * Q16.16 gain, truncated toward zero into Q26.5, saturated
    function logic [31:0] scale_value(logic [31:0] field, logic [7:0] vofs,
                                      logic [31:0] gain);
        longint    sum;
        longint    a;
        longint    b;
        bit [63:0] p;
        bit [63:0] q;
        bit [63:0] lim;
        bit        neg;
        sum = longint'({32'b0, field}) + longint'($signed(vofs));
        a   = (sum < 0) ? -sum : sum;
        b   = ($signed(gain) < 0) ? -longint'($signed(gain)) : longint'($signed(gain));
        p   = a * b;
        neg = ((sum < 0) != ($signed(gain) < 0)) && (p != 0);
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        q   = p >> (GAIN_FRACTION_BITS - VALUE_FRACTION_BITS);
        if (q > lim) q = lim;
        return neg ? (32'd0 - q[31:0]) : q[31:0];
    endfunction

    function void push(t_kind kind, logic [2:0] st, logic [4:0] cnt, logic [15:0] prm,
                       logic [31:0] val, logic lst);
        t_unpack_result r;
        r.kind = kind; r.status = st; r.msg_count = cnt;
        r.param = prm; r.value = val; r.last = lst;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted request and queue the items it causes
    function void note_request(logic [1:0] op, logic [31:0] id, logic [15:0] prm,
                               logic [7:0] off, logic [7:0] len, logic [31:0] gain,
                               logic [7:0] vofs, logic [31:0] lo, logic [31:0] hi);
        int          m;
        int          fr;
        int          idx;
        int          tail;
        int          n;
        logic [2:0]  st;
        logic [32:0] mask;
        logic [31:0] field;
        if (op == OP_ADD) begin
            st = ST_OK;
            if (id > MAX_ID) st = ST_BAD_ID;
            else if (off > MAX_OFFSET) st = ST_BAD_OFFSET;
            else if (len > MAX_LENGTH) st = ST_BAD_LENGTH;
            else begin
                m = find_msg(id);
                if (m < 0) begin
                    for (int i = 0; i < MESSAGE_SLOTS; i++) begin
                        if (msg_head[i] == CHAIN_END) begin
                            m = i;
                            break;
                        end
                    end
                    // id lands in the slot even when items turn out full
                    if (m < 0) st = ST_MSG_FULL;
                    else msg_ident[m] = id;
                end
                if (st == ST_OK) begin
                    fr = 0;
                    while (fr < ITEM_SLOTS && it_link[fr] != LINK_FREE) fr++;
                    if (fr == ITEM_SLOTS) st = ST_ITEM_FULL;
                    else begin
                        idx  = msg_head[m];
                        tail = CHAIN_END;
                        n    = 0;
                        while (idx < CHAIN_END && n < ITEM_SLOTS) begin
                            tail = idx;
                            idx  = it_link[idx];
                            n++;
                        end
                        it_param[fr] = prm;
                        it_off[fr]   = off[5:0];
                        it_len[fr]   = len[5:0];
                        it_vofs[fr]  = vofs;
                        it_gain[fr]  = gain;
                        it_link[fr]  = CHAIN_END;
                        if (tail == CHAIN_END) msg_head[m] = fr;
                        else it_link[tail] = fr;
                    end
                end
            end
            push(KIND_STATUS, st, 5'(count_msgs()), '0, '0, 1'b1);
        end else if (op == OP_FRAME) begin
            m = find_msg(id);
            if (m < 0) begin
                push(KIND_UNMAPPED, ST_OK, '0, '0, '0, 1'b1);
            end else begin
                idx = msg_head[m];
                n   = 0;
                while (idx < CHAIN_END && n < ITEM_SLOTS) begin
                    mask  = (33'd1 << it_len[idx]) - 33'd1;
                    if (it_off[idx] > 31) field = (hi >> (it_off[idx] - 32)) & mask[31:0];
                    else field = (lo >> it_off[idx]) & mask[31:0];
                    push(KIND_WRITE, ST_OK, '0, it_param[idx],
                         scale_value(field, it_vofs[idx], it_gain[idx]), 1'b0);
                    n++;
                    idx = it_link[idx];
                end
                if (n > 0) pending_results[$].last = 1'b1;
            end
        end else if (op == OP_CLEAR) begin
            clear_map();
        end
    endfunction

    // Compare one accepted result item with the oldest expectation
    function void check_result(logic [1:0] kind, logic [55:0] data, logic lst);
        t_unpack_result e;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind=%0d data=%h last=%0b", kind, data, lst);
            return;
        end
        e = pending_results.pop_front();
        if (kind !== e.kind || data[2:0] !== e.status || data[7:3] !== e.msg_count ||
            data[23:8] !== e.param || data[55:24] !== e.value || lst !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp kind=%0d st=%0d cnt=%0d prm=%h val=%h last=%0b",
                          " | act kind=%0d st=%0d cnt=%0d prm=%h val=%h last=%0b"},
                         e.kind, e.status, e.msg_count, e.param, e.value, e.last,
                         kind, data[2:0], data[7:3], data[23:8], data[55:24], lst);
        end
    endfunction
endclass

module tb_can_signal_map_unpacker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NOP = 2'd3;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    unpack_scoreboard sb = new();
    logic [31:0]      id_pool[20];
    bit               tx_busy_run = 1'b0;
    bit               rx_busy_run = 1'b0;

    can_signal_map_unpacker_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hold the run within a fixed budget
    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Drive one request item after a random gap, return once it is taken
    task automatic send_request(logic [1:0] op, logic [31:0] id, logic [15:0] prm,
                                logic [7:0] off, logic [7:0] len, logic [31:0] gain,
                                logic [7:0] vofs, logic [31:0] lo, logic [31:0] hi);
        int gap;
        gap = tx_busy_run ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {hi, lo, vofs, gain, len, off, prm, id};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_request(op, id, prm, off, len, gain, vofs, lo, hi);
    endtask

    task automatic add_map(logic [31:0] id, logic [15:0] prm, logic [7:0] off,
                           logic [7:0] len, logic [31:0] gain, logic [7:0] vofs);
        send_request(OP_ADD, id, prm, off, len, gain, vofs, $urandom, $urandom);
    endtask

    task automatic send_frame(logic [31:0] id, logic [31:0] lo, logic [31:0] hi);
        send_request(OP_FRAME, id, 16'($urandom), 8'($urandom), 8'($urandom), $urandom,
                     8'($urandom), lo, hi);
    endtask

    // Drop the request and wait until every expected result has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    // Random add: mostly well-formed, sometimes a bad argument
    task automatic random_add();
        logic [31:0] id;
        logic [7:0]  off;
        logic [7:0]  len;
        id  = id_pool[$urandom_range(0, 19)];
        off = 8'($urandom_range(0, 63));
        len = ($urandom_range(0, 3) == 0) ? 8'd32 : 8'($urandom_range(0, 32));
        case ($urandom_range(0, 15))
            0: id  = $urandom;
            1: off = 8'($urandom);
            2: len = 8'($urandom);
            default: ;
        endcase
        add_map(id, 16'($urandom), off, len, $urandom, 8'($urandom));
    endtask

    // Result side: random stalls with stretches of none
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 40) == 0) rx_busy_run = !rx_busy_run;
            gap = rx_busy_run ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        int          r;
        int          guard;
        logic [31:0] id_a;
        for (int i = 0; i < 20; i++) begin
            id_pool[i] = (i < 8) ? 32'(i) : ($urandom & MAX_ID);
        end
        id_pool[19] = MAX_ID;
        id_a = $urandom & MAX_ID;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: argument checks in order, extreme fields, unmapped and clear
        add_map(32'hffff_ffff, 16'hffff, 8'hff, 8'hff, 32'hffff_ffff, 8'hff);
        add_map(MAX_ID + 1, 16'h0, 8'd0, 8'd0, 32'h0, 8'h0);
        add_map(id_a, 16'h1234, 8'd64, 8'd8, 32'h1_0000, 8'h0);
        add_map(id_a, 16'h1234, 8'hff, 8'hff, 32'h1_0000, 8'h0);
        add_map(id_a, 16'h1234, 8'd63, 8'd33, 32'h1_0000, 8'h0);
        send_frame(id_a, $urandom, $urandom);
        add_map(id_a, 16'hffff, 8'd0, 8'd32, 32'h7fff_ffff, 8'h7f);
        add_map(id_a, 16'h0000, 8'd63, 8'd1, 32'h8000_0000, 8'h80);
        add_map(id_a, 16'h5a5a, 8'd32, 8'd32, 32'hffff_0000, 8'h00);
        add_map(id_a, 16'ha5a5, 8'd31, 8'd8, 32'h0001_0000, 8'hff);
        add_map(id_a, 16'h0f0f, 8'd5, 8'd0, 32'h0000_0000, 8'h01);
        add_map(MAX_ID, 16'h00ff, 8'd0, 8'd16, 32'hfffe_8000, 8'h80);
        send_frame(id_a, 32'hffff_ffff, 32'hffff_ffff);
        send_frame(id_a, 32'h0, 32'h0);
        send_frame(id_a, $urandom, $urandom);
        send_frame(MAX_ID, $urandom, $urandom);
        send_frame(id_a | 32'h2000_0000, $urandom, $urandom);
        send_request(OP_NOP, id_a, 16'($urandom), 8'($urandom), 8'($urandom), $urandom,
                     8'($urandom), $urandom, $urandom);
        send_request(OP_CLEAR, $urandom, 16'($urandom), 8'($urandom), 8'($urandom),
                     $urandom, 8'($urandom), $urandom, $urandom);
        send_frame(id_a, $urandom, $urandom);

        // Random: mostly adds and frames on a small id set, rare clears
        for (int n = 0; n < 330; n++) begin
            if ($urandom_range(0, 30) == 0) tx_busy_run = !tx_busy_run;
            if (n == 165) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 45) random_add();
            else if (r < 96) begin
                if (r < 50) send_frame($urandom, $urandom, $urandom);
                else send_frame(id_pool[$urandom_range(0, 19)], $urandom, $urandom);
            end else if (r < 98) begin
                send_request(OP_NOP, $urandom, 16'($urandom), 8'($urandom), 8'($urandom),
                             $urandom, 8'($urandom), $urandom, $urandom);
            end else begin
                send_request(OP_CLEAR, $urandom, 16'($urandom), 8'($urandom), 8'($urandom),
                             $urandom, 8'($urandom), $urandom, $urandom);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow trailing cycles for any stray item
        guard = 0;
        while (sb.pending_results.size() != 0 && guard < 2_000_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire

[filelist.f]
rtl/cmsu_pkg.sv
rtl/cmsu_mul.sv
rtl/can_signal_map_unpacker_core.sv
rtl/cmsu_checker.sv
verif/tb_can_signal_map_unpacker_core.sv
